// ----- rtl/convex_hull_gift_wrap_unit_assert.svh -----
// Assertion macros for the convex hull gift wrap unit.
// Included by the top level; no other dependencies.
`ifndef CONVEX_HULL_GIFT_WRAP_UNIT_ASSERT_SVH
`define CONVEX_HULL_GIFT_WRAP_UNIT_ASSERT_SVH
`ifndef SYNTH
`define CHGW_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("chgw assertion failed");
`define CHGW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chgw implication failed");
`define CHGW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chgw next-cycle check failed");
`else
`define CHGW_ASSERT(label, clk, rst_n, cond)
`define CHGW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CHGW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/chgw_pkg.sv -----
// Shared constants and types for the convex hull gift wrap unit.
// No dependencies.
`default_nettype none
package chgw_pkg;
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int WORD_W     = 2 * COORD_W;
    localparam int MIN_HULL   = 3;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_FEW = 2'd1,
        ST_CUT = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_LOAD,
        S_MRD,
        S_MCMP,
        S_CRD,
        S_CLD,
        S_MA,
        S_MB,
        S_CMP,
        S_STEP,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

// ----- rtl/convex_hull_gift_wrap_unit.sv -----
// Convex hull by gift wrapping: point store, sequencer and shared product unit.
// Depends on chgw_pkg, chgw_ram, chgw_cross and the assertion header.
//
// channel   direction  handshake            payload
// points    in         i_valid / o_ready    i_x, i_y, i_last
// vertices  out        o_valid / i_ready    o_x_res, o_y_res, o_last_res, o_status
//
// Loading accepts one point per cycle. After the last point the start search runs
// and then one hull step per vertex; one multiplier does both products of every
// turn test in turn. Reset clears the point count and returns to loading. No
// points are taken while the walk runs or a vertex waits.
`default_nettype none
`include "convex_hull_gift_wrap_unit_assert.svh"
module convex_hull_gift_wrap_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [chgw_pkg::COORD_W-1:0] i_x,
    input  wire logic signed [chgw_pkg::COORD_W-1:0] i_y,
    input  wire logic                                i_last,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic      signed [chgw_pkg::COORD_W-1:0] o_x_res,
    output logic      signed [chgw_pkg::COORD_W-1:0] o_y_res,
    output logic                                     o_last_res,
    output chgw_pkg::t_status                        o_status
);
    import chgw_pkg::*;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_n, n_n;
    logic [CNT_W-1:0]          r_i, n_i;
    logic [CNT_W-1:0]          r_k, n_k;
    logic [IDX_W-1:0]          r_start, n_start;
    logic [IDX_W-1:0]          r_p, n_p;
    logic [IDX_W-1:0]          r_c, n_c;
    logic signed [COORD_W-1:0] r_px, n_px, r_py, n_py;
    logic signed [COORD_W-1:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [COORD_W-1:0] r_ix, n_ix, r_iy, n_iy;
    logic signed [PROD_W-1:0]  r_a, n_a;
    logic                      r_done, n_done;
    logic signed [COORD_W-1:0] r_ox, n_ox, r_oy, n_oy;
    logic                      r_olast, n_olast;
    t_status                   r_ost, n_ost;

    logic                      we;
    logic [IDX_W-1:0]          raddr;
    logic [WORD_W-1:0]         rdata;
    logic signed [COORD_W-1:0] rd_x, rd_y;
    logic signed [COORD_W-1:0] m_a1, m_b1, m_a2, m_b2;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W:0]    turn;
    logic [CNT_W-1:0]          i_next;
    logic [CNT_W-1:0]          c_next;
    logic [CNT_W-1:0]          n_total;
    logic                      not_full;

    assign rd_x     = rdata[COORD_W-1:0];
    assign rd_y     = rdata[WORD_W-1:COORD_W];
    assign i_next   = r_i + CNT_W'(1);
    assign c_next   = {1'b0, r_p} + CNT_W'(1);
    assign not_full = r_count < CNT_W'(MAX_POINTS);
    assign n_total  = not_full ? r_count + CNT_W'(1) : r_count;
    assign turn     = {r_a[PROD_W-1], r_a} - {prod[PROD_W-1], prod};
    assign we       = (r_state == S_LOAD) && i_valid && not_full;

    chgw_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({i_y, i_x}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    chgw_cross u_cross (
        .i_clk  (i_clk),
        .i_a1   (m_a1),
        .i_b1   (m_b1),
        .i_a2   (m_a2),
        .i_b2   (m_b2),
        .o_prod (prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_k     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_k     <= n_k;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_i     <= n_i;
        r_start <= n_start;
        r_p     <= n_p;
        r_c     <= n_c;
        r_px    <= n_px;
        r_py    <= n_py;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_ix    <= n_ix;
        r_iy    <= n_iy;
        r_a     <= n_a;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_olast <= n_olast;
        r_ost   <= n_ost;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_n     = r_n;
        n_i     = r_i;
        n_k     = r_k;
        n_start = r_start;
        n_p     = r_p;
        n_c     = r_c;
        n_px    = r_px;
        n_py    = r_py;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_ix    = r_ix;
        n_iy    = r_iy;
        n_a     = r_a;
        n_done  = r_done;
        n_ox    = r_ox;
        n_oy    = r_oy;
        n_olast = r_olast;
        n_ost   = r_ost;
        raddr   = r_i[IDX_W-1:0];
        m_a1    = rd_y;
        m_b1    = r_py;
        m_a2    = r_cx;
        m_b2    = rd_x;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_count = n_total;
                    if (i_last) begin
                        n_n     = n_total;
                        n_count = '0;
                        if (n_total < CNT_W'(MIN_HULL)) begin
                            n_ox    = '0;
                            n_oy    = '0;
                            n_olast = 1'b1;
                            n_ost   = ST_FEW;
                            n_done  = 1'b1;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_MRD;
                        end
                    end
                end
            end
            S_MRD: begin
                raddr   = '0;
                n_i     = '0;
                n_state = S_MCMP;
            end
            S_MCMP: begin
                raddr = i_next[IDX_W-1:0];
                if (r_i == '0 || rd_x < r_px) begin
                    n_start = r_i[IDX_W-1:0];
                    n_p     = r_i[IDX_W-1:0];
                    n_px    = rd_x;
                    n_py    = rd_y;
                end
                n_i = i_next;
                if (i_next == r_n) begin
                    n_k     = '0;
                    n_state = S_CRD;
                end
            end
            S_CRD: begin
                if (c_next == r_n) begin
                    raddr = '0;
                    n_c   = '0;
                end else begin
                    raddr = c_next[IDX_W-1:0];
                    n_c   = c_next[IDX_W-1:0];
                end
                n_state = S_CLD;
            end
            S_CLD: begin
                n_cx    = rd_x;
                n_cy    = rd_y;
                raddr   = '0;
                n_i     = '0;
                n_state = S_MA;
            end
            S_MA: begin
                n_ix    = rd_x;
                n_iy    = rd_y;
                n_state = S_MB;
            end
            S_MB: begin
                m_a1    = r_ix;
                m_b1    = r_px;
                m_a2    = r_cy;
                m_b2    = r_iy;
                n_a     = prod;
                n_state = S_CMP;
            end
            S_CMP: begin
                raddr = i_next[IDX_W-1:0];
                if (turn[PROD_W]) begin
                    n_c  = r_i[IDX_W-1:0];
                    n_cx = r_ix;
                    n_cy = r_iy;
                end
                n_i = i_next;
                if (i_next == r_n) begin
                    n_state = S_STEP;
                end else begin
                    n_state = S_MA;
                end
            end
            S_STEP: begin
                n_state = S_OUT;
                if (r_c == r_start) begin
                    n_ox    = r_px;
                    n_oy    = r_py;
                    n_olast = 1'b1;
                    n_ost   = ST_OK;
                    n_done  = 1'b1;
                end else if (r_k >= CNT_W'(MAX_POINTS - 1)) begin
                    n_ox    = '0;
                    n_oy    = '0;
                    n_olast = 1'b1;
                    n_ost   = ST_CUT;
                    n_done  = 1'b1;
                end else begin
                    n_ox    = r_px;
                    n_oy    = r_py;
                    n_olast = 1'b0;
                    n_ost   = ST_OK;
                    n_done  = 1'b0;
                    n_k     = r_k + CNT_W'(1);
                    n_p     = r_c;
                    n_px    = r_cx;
                    n_py    = r_cy;
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_done  = 1'b0;
                    n_state = r_done ? S_LOAD : S_CRD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_x_res    = r_ox;
    assign o_y_res    = r_oy;
    assign o_last_res = r_olast;
    assign o_status   = r_ost;

    `CHGW_ASSERT(a_no_overlap, i_clk, i_rst_n, !(o_ready && o_valid))
    `CHGW_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= CNT_W'(MAX_POINTS))
    `CHGW_ASSERT_IMP(a_bad_status_last, i_clk, i_rst_n, o_valid && o_status != ST_OK, o_last_res && o_x_res == '0 && o_y_res == '0)
    `CHGW_ASSERT_NXT(a_last_reloads, i_clk, i_rst_n, o_valid && i_ready && o_last_res, o_ready)
    `CHGW_ASSERT(a_walk_bound, i_clk, i_rst_n, r_k < CNT_W'(MAX_POINTS))
endmodule
`default_nettype wire

// ----- rtl/chgw_ram.sv -----
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none
module chgw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/chgw_cross.sv -----
// Shared difference-product unit: registered (a1-b1)*(a2-b2).
// Depends on chgw_pkg.
`default_nettype none
module chgw_cross (
    input  wire logic                                 i_clk,
    input  wire logic signed [chgw_pkg::COORD_W-1:0]  i_a1,
    input  wire logic signed [chgw_pkg::COORD_W-1:0]  i_b1,
    input  wire logic signed [chgw_pkg::COORD_W-1:0]  i_a2,
    input  wire logic signed [chgw_pkg::COORD_W-1:0]  i_b2,
    output logic      signed [chgw_pkg::PROD_W-1:0]   o_prod
);
    import chgw_pkg::*;

    logic signed [DIFF_W-1:0] d1;
    logic signed [DIFF_W-1:0] d2;

    assign d1 = {i_a1[COORD_W-1], i_a1} - {i_b1[COORD_W-1], i_b1};
    assign d2 = {i_a2[COORD_W-1], i_a2} - {i_b2[COORD_W-1], i_b2};

    always_ff @(posedge i_clk) begin
        o_prod <= d1 * d2;
    end
endmodule
`default_nettype wire
